FILE: sv/kti_pkg.sv
`default_nettype none
package kti_pkg;
	localparam int MAX_TRACKS = 8;
	localparam int MAX_FRAMES = 16;
	localparam int TW = $clog2(MAX_TRACKS);
	localparam int FW = $clog2(MAX_FRAMES);
	localparam int NW = $clog2(MAX_FRAMES + 1);
	localparam int AW = TW + FW;

	localparam logic [2:0] MODE_TICK = 3'd0;
	localparam logic [2:0] MODE_ADDKEY = 3'd1;
	localparam logic [2:0] MODE_ADDFRAME = 3'd2;
	localparam logic [2:0] MODE_REMOVE = 3'd3;
	localparam logic [2:0] MODE_QUERY = 3'd4;
	localparam logic [2:0] MODE_START = 3'd5;
	localparam logic [2:0] MODE_STOP = 3'd6;
	localparam logic [2:0] MODE_TOGGLE = 3'd7;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_NO_TRACK = 3'd1;
	localparam logic [2:0] ST_EXISTS = 3'd2;
	localparam logic [2:0] ST_TABLE_FULL = 3'd3;
	localparam logic [2:0] ST_FRAMES_FULL = 3'd4;

	localparam logic [1:0] REG_LENGTH = 2'd0;
	localparam logic [1:0] REG_LOOP = 2'd1;
	localparam logic [1:0] REG_BACK = 2'd2;

	typedef struct packed {
		logic start;
		logic [15:0] dividend;
		logic [15:0] divisor;
	} div_req_t;
endpackage
`default_nettype wire

FILE: sv/kti_divider.sv
`default_nettype none
// Restoring divider: ({dividend,16'b0}) / divisor, one quotient bit a cycle.
// The dividend is below the divisor, so the remainder starts at the dividend and
// sixteen steps give the whole quotient.
module kti_divider import kti_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire div_req_t req,
	output logic busy,
	output logic [15:0] quotient
);
	logic [4:0] cnt_q;
	logic [32:0] rem_q;
	logic [15:0] den_q;
	logic [32:0] trial;

	assign trial = {rem_q[31:0], 1'b0} - {17'd0, den_q};
	assign busy = cnt_q != 5'd0;

	// One shift and subtract step each cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 5'd0;
		end else if (req.start) begin
			cnt_q <= 5'd16;
		end else if (busy) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {17'd0, req.dividend};
			den_q <= req.divisor;
			quotient <= 16'd0;
		end else if (busy) begin
			if (!trial[32]) begin
				rem_q <= trial;
				quotient <= {quotient[14:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], 1'b0};
				quotient <= {quotient[14:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

FILE: sv/keyframe_track_interpolator_unit.sv
`default_nettype none
// Channel | direction | contents
// s_axis  | in        | tuser mode[2:0]; tdata track_id, time_arg, first_value, second_value
// m_axis  | out       | tdata track_value, status, is_playing, playhead, pad
// cfg     | in        | index, data (timeline_length, loop_mode, play_backward)
// Tick, start, stop, toggle and remove items pass only through the track search, the
// dispatch and the output states; a query that lands on the last frame takes longest. The
// track search, the frame search and shift over the single-port frame memory and the
// 16-step divider set how long an item takes. Reset clears the track table and playhead at once.
// The input is not ready while an item is at work or a result waits to be taken.
module keyframe_track_interpolator_unit import kti_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [95:0] s_axis_tdata, // track_id, time_arg, first_value, second_value
	input wire logic [2:0] s_axis_tuser, // mode
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [55:0] m_axis_tdata, // track_value, status, is_playing, playhead, pad
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [15:0] cfg_data
);
	localparam logic [3:0] S_IDLE = 4'd0, S_FIND = 4'd1, S_DISP = 4'd2, S_SRD = 4'd3,
		S_SCMP = 4'd4, S_SHIFT = 4'd5, S_SWR = 4'd6, S_PUT = 4'd7, S_QWAIT = 4'd8,
		S_DIV = 4'd9, S_DIVW = 4'd10, S_MUL = 4'd11, S_OUT = 4'd12, S_QPREV = 4'd13;

	logic [3:0] state_q;
	logic [15:0] len_q;
	logic loop_q, back_q;
	logic [MAX_TRACKS-1:0] used_q;
	logic [15:0] ident_q [MAX_TRACKS];
	logic [NW-1:0] total_q [MAX_TRACKS];
	logic [16:0] play_q;
	logic act_q;

	logic [2:0] mode_q;
	logic [15:0] id_q, targ_q;
	logic signed [31:0] v1_q, v2_q;
	logic [TW:0] k_q;
	logic [TW-1:0] trk_q;
	logic found_q;
	logic [NW-1:0] i_q;
	logic second_q;
	logic [15:0] ins_t_q;
	logic signed [31:0] ins_v_q;
	logic [15:0] t1_q, t0_q;
	logic signed [31:0] fv1_q, fv0_q;
	logic signed [31:0] res_v_q;
	logic [2:0] res_s_q;
	logic signed [63:0] prod_q;

	// Frame memory, one port, registered read.
	logic [15:0] mt [MAX_TRACKS*MAX_FRAMES];
	logic [31:0] mv [MAX_TRACKS*MAX_FRAMES];
	logic [AW-1:0] ra, wa;
	logic we;
	logic [15:0] rt_q, wt;
	logic [31:0] rv_q, wv;
	always_ff @(posedge clk) begin
		if (we) begin
			mt[wa] <= wt;
			mv[wa] <= wv;
		end
		rt_q <= mt[ra];
		rv_q <= mv[ra];
	end

	div_req_t dreq;
	logic dbusy;
	logic [15:0] dq;
	kti_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .busy(dbusy), .quotient(dq));

	logic [NW-1:0] n_cur;
	logic [FW-1:0] i_lo, i_m1;
	assign n_cur = total_q[trk_q];
	assign i_lo = i_q[FW-1:0];
	assign i_m1 = FW'(i_q - NW'(1));

	logic signed [32:0] dv;
	logic signed [63:0] step;
	assign dv = 33'(fv1_q) - 33'(fv0_q);
	assign step = prod_q >>> 16;

	logic signed [17:0] tnext;

	// Lowest free slot of the track table.
	logic [TW-1:0] free_idx;
	always_comb begin
		free_idx = '0;
		for (int k = MAX_TRACKS-1; k >= 0; k--)
			if (!used_q[k]) free_idx = TW'(k);
	end

	assign s_axis_tready = state_q == S_IDLE && !m_axis_tvalid;
	assign cfg_ready = 1'b1;

	// Memory addressing follows the sequencer state.
	always_comb begin
		ra = {trk_q, i_lo};
		we = 1'b0;
		wa = {trk_q, i_lo};
		wt = ins_t_q;
		wv = ins_v_q;
		dreq = '0;
		if (state_q == S_SHIFT) ra = {trk_q, i_m1};
		if (state_q == S_SWR) begin
			we = 1'b1;
			wt = rt_q;
			wv = rv_q;
		end
		if (state_q == S_PUT) we = 1'b1;
		if (state_q == S_QPREV) ra = {trk_q, i_m1};
		if (state_q == S_DIV) begin
			dreq.start = 1'b1;
			dreq.dividend = play_q[15:0] - t0_q;
			dreq.divisor = t1_q - t0_q;
		end
		if (back_q) tnext = $signed({1'b0, play_q}) - $signed({2'b0, targ_q});
		else tnext = $signed({1'b0, play_q}) + $signed({2'b0, targ_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q <= 16'd256;
			loop_q <= 1'b1;
			back_q <= 1'b0;
			used_q <= '0;
			for (int k = 0; k < MAX_TRACKS; k++) total_q[k] <= '0;
			play_q <= '0;
			act_q <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_LENGTH: len_q <= cfg_data;
					REG_LOOP: loop_q <= cfg_data[0];
					REG_BACK: back_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
			case (state_q)
				S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					state_q <= S_FIND;
					k_q <= '0;
					found_q <= 1'b0;
				end
				// Track search, one slot a cycle.
				S_FIND: begin
					if (k_q == (TW+1)'(MAX_TRACKS)) begin
						state_q <= S_DISP;
					end else begin
						if (used_q[k_q[TW-1:0]] && ident_q[k_q[TW-1:0]] == id_q && !found_q) begin
							found_q <= 1'b1;
							trk_q <= k_q[TW-1:0];
						end
						k_q <= k_q + (TW+1)'(1);
					end
				end
				S_DISP: begin
					res_v_q <= '0;
					i_q <= '0;
					second_q <= 1'b0;
					case (mode_q)
						MODE_TICK: begin
							res_s_q <= ST_OK;
							state_q <= S_OUT;
							if (act_q) begin
								if (tnext > $signed({2'b0, len_q}) || tnext < 0) begin
									if (loop_q) play_q <= back_q ? {1'b0, len_q} : 17'd0;
									else begin
										play_q <= back_q ? 17'd0 : {1'b0, len_q};
										act_q <= 1'b0;
									end
								end else play_q <= tnext[16:0];
							end
						end
						MODE_ADDKEY: begin
							if (found_q) begin
								res_s_q <= ST_EXISTS;
								state_q <= S_OUT;
							end else if (&used_q) begin
								res_s_q <= ST_TABLE_FULL;
								state_q <= S_OUT;
							end else begin
								res_s_q <= ST_OK;
								trk_q <= free_idx;
								used_q[free_idx] <= 1'b1;
								ident_q[free_idx] <= id_q;
								total_q[free_idx] <= '0;
								ins_t_q <= 16'd0;
								ins_v_q <= v1_q;
								state_q <= S_SRD;
							end
						end
						MODE_ADDFRAME: begin
							if (!found_q) begin
								res_s_q <= ST_NO_TRACK;
								state_q <= S_OUT;
							end else if (total_q[trk_q] >= NW'(MAX_FRAMES)) begin
								res_s_q <= ST_FRAMES_FULL;
								state_q <= S_OUT;
							end else begin
								res_s_q <= ST_OK;
								ins_t_q <= targ_q;
								ins_v_q <= v1_q;
								state_q <= S_SRD;
							end
						end
						MODE_REMOVE: begin
							state_q <= S_OUT;
							if (!found_q) res_s_q <= ST_NO_TRACK;
							else begin
								res_s_q <= ST_OK;
								used_q[trk_q] <= 1'b0;
								total_q[trk_q] <= '0;
							end
						end
						MODE_QUERY: begin
							if (!found_q) begin
								res_s_q <= ST_NO_TRACK;
								state_q <= S_OUT;
							end else begin
								res_s_q <= ST_OK;
								state_q <= (total_q[trk_q] != '0) ? S_SRD : S_OUT;
							end
						end
						MODE_START: begin
							res_s_q <= ST_OK;
							state_q <= S_OUT;
							play_q <= back_q ? {1'b0, len_q} : 17'd0;
							act_q <= 1'b1;
						end
						MODE_STOP: begin
							res_s_q <= ST_OK;
							state_q <= S_OUT;
							play_q <= back_q ? {1'b0, len_q} : 17'd0;
							act_q <= 1'b0;
						end
						default: begin
							res_s_q <= ST_OK;
							state_q <= S_OUT;
							act_q <= !act_q;
						end
					endcase
				end
				// Frame search: read entry i, compare next cycle.
				S_SRD: begin
					if (i_q == n_cur) begin
						if (mode_q == MODE_QUERY) begin
							i_q <= i_q;
							state_q <= S_QPREV;
							found_q <= 1'b0;
						end else begin
							i_q <= n_cur;
							t0_q <= {{(16-NW){1'b0}}, n_cur};
							state_q <= (n_cur == '0) ? S_PUT : S_SHIFT;
						end
					end else state_q <= S_SCMP;
				end
				S_SCMP: begin
					if (mode_q == MODE_QUERY) begin
						if (play_q < {1'b0, rt_q}) begin
							t1_q <= rt_q;
							fv1_q <= rv_q;
							found_q <= 1'b1;
							if (i_q == '0) begin
								t0_q <= 16'd0;
								fv0_q <= '0;
								state_q <= S_DIV;
							end else state_q <= S_QPREV;
						end else begin
							i_q <= i_q + NW'(1);
							state_q <= S_SRD;
						end
					end else if (ins_t_q < rt_q) begin
						// Insertion point found; shift from the top down.
						i_q <= n_cur;
						state_q <= S_SHIFT;
						t0_q <= {{(16-NW){1'b0}}, i_q};
					end else begin
						i_q <= i_q + NW'(1);
						state_q <= S_SRD;
					end
				end
				S_QPREV: state_q <= S_QWAIT;
				S_QWAIT: begin
					if (!found_q) begin
						res_v_q <= rv_q;
						state_q <= S_OUT;
					end else begin
						t0_q <= rt_q;
						fv0_q <= rv_q;
						state_q <= S_DIV;
					end
				end
				S_SHIFT: begin
					// i_q counts down; the read of i-1 lands next cycle.
					if (i_q == NW'(t0_q[NW-1:0]) || i_q == '0) state_q <= S_PUT;
					else state_q <= S_SWR;
				end
				S_SWR: begin
					i_q <= i_q - NW'(1);
					state_q <= S_SHIFT;
				end
				S_PUT: begin
					total_q[trk_q] <= n_cur + NW'(1);
					if (mode_q == MODE_ADDKEY && !second_q) begin
						second_q <= 1'b1;
						ins_t_q <= len_q;
						ins_v_q <= v2_q;
						i_q <= '0;
						state_q <= S_SRD;
					end else state_q <= S_OUT;
				end
				S_DIV: state_q <= S_DIVW;
				S_DIVW: if (!dbusy) state_q <= S_MUL;
				S_MUL: begin
					prod_q <= 64'(dv) * $signed({48'd0, dq});
					state_q <= S_OUT;
					res_s_q <= 3'd7;
				end
				S_OUT: begin
					if (res_s_q == 3'd7) begin
						res_v_q <= 32'(fv0_q + step[31:0]);
						res_s_q <= ST_OK;
					end else begin
						m_axis_tvalid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Capture the item.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_axis_tvalid && s_axis_tready) begin
			mode_q <= s_axis_tuser;
			id_q <= s_axis_tdata[15:0];
			targ_q <= s_axis_tdata[31:16];
			v1_q <= s_axis_tdata[63:32];
			v2_q <= s_axis_tdata[95:64];
		end
	end

	assign m_axis_tdata = {4'd0, play_q[15:0], act_q, res_s_q, res_v_q};
endmodule
`default_nettype wire

FILE: sv/kti_checker.sv
`default_nettype none
module kti_checker import kti_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	input wire logic s_axis_tready,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [55:0] m_axis_tdata
);
	// A waiting result holds still.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");
	// No input is taken while a result waits.
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("ready with pending result");
	// Status codes stay in range.
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[34:32] <= ST_FRAMES_FULL)
		else $error("bad status");
	// An accepted item is not answered in the next cycle.
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
		else $error("result too early");
endmodule
bind keyframe_track_interpolator_unit kti_checker u_chk (.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata));
`default_nettype wire
